>>> rtl/core/wrd_pkg.sv
// wrd_pkg: shared constants for the wide restoring divider
// no dependencies; used by the channel interfaces and all divider modules
package wrd_pkg;

  // word layout of the operand and result fields
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned NUM_WORDS = 3;
  localparam int unsigned MAX_BITS  = WORD_BITS * NUM_WORDS;

  // default operand width handed to the top level
  localparam int unsigned DEFAULT_OPERAND_BITS = 192;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [MAX_BITS-1:0]  wide_t;

endpackage

>>> rtl/core/wrd_in_if.sv
// wrd_in_if: input channel of the divider, valid/ready plus dividend and divisor words
// depends on wrd_pkg
interface wrd_in_if
  import wrd_pkg::*;
();

  logic  valid;
  logic  ready;
  word_t dividend_lo;
  word_t dividend_mid;
  word_t dividend_hi;
  word_t divisor_lo;
  word_t divisor_mid;
  word_t divisor_hi;

  modport source (
    output valid, dividend_lo, dividend_mid, dividend_hi,
           divisor_lo, divisor_mid, divisor_hi,
    input  ready
  );

  modport sink (
    input  valid, dividend_lo, dividend_mid, dividend_hi,
           divisor_lo, divisor_mid, divisor_hi,
    output ready
  );

endinterface

>>> rtl/core/wrd_out_if.sv
// wrd_out_if: result channel of the divider, valid/ready plus quotient, remainder and flag
// depends on wrd_pkg
interface wrd_out_if
  import wrd_pkg::*;
();

  logic  valid;
  logic  ready;
  word_t quotient_lo;
  word_t quotient_mid;
  word_t quotient_hi;
  word_t remainder_lo;
  word_t remainder_mid;
  word_t remainder_hi;
  logic  divide_by_zero;

  modport source (
    output valid, quotient_lo, quotient_mid, quotient_hi,
           remainder_lo, remainder_mid, remainder_hi, divide_by_zero,
    input  ready
  );

  modport sink (
    input  valid, quotient_lo, quotient_mid, quotient_hi,
           remainder_lo, remainder_mid, remainder_hi, divide_by_zero,
    output ready
  );

endinterface

>>> rtl/core/wide_restoring_divider.sv
// Unsigned restoring divider for OPERAND_BITS-wide operands carried as three 64-bit
// words; input bits at and above OPERAND_BITS are ignored. One word is accepted, then a
// single shared shift-and-subtract unit produces one quotient bit per cycle, most
// significant first, one for each of the OPERAND_BITS operand bits, and the result is
// then moved to an output register. A new word is taken once the previous result has
// been moved to the output register; a result still waiting in the output register
// holds off that move. A zero divisor skips the steps, raises divide_by_zero and
// returns quotient 0 with the dividend as remainder.
// depends on wrd_pkg, wrd_in_if, wrd_out_if and wrd_step
module wide_restoring_divider
  import wrd_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = DEFAULT_OPERAND_BITS
) (
  input  logic      clk,
  input  logic      rst,
  wrd_in_if.sink    in,
  wrd_out_if.source out
);

  localparam int unsigned CNT_W = $clog2(OPERAND_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        cnt;
  logic [OPERAND_BITS-1:0] num;
  logic [OPERAND_BITS-1:0] rem;
  logic [OPERAND_BITS-1:0] div;
  logic                    dz;

  logic                    out_valid;
  wide_t                   out_quo;
  wide_t                   out_rem;
  logic                    out_dz;

  wide_t                   in_dividend;
  wide_t                   in_divisor;
  logic [OPERAND_BITS-1:0] dividend_trim;
  logic [OPERAND_BITS-1:0] divisor_trim;
  logic [OPERAND_BITS-1:0] rem_next;
  logic                    quo_bit;
  logic                    out_free;
  logic                    load_out;

  // gather the words and drop bits above the operand width
  assign in_dividend   = {in.dividend_hi, in.dividend_mid, in.dividend_lo};
  assign in_divisor    = {in.divisor_hi, in.divisor_mid, in.divisor_lo};
  assign dividend_trim = in_dividend[OPERAND_BITS-1:0];
  assign divisor_trim  = in_divisor[OPERAND_BITS-1:0];

  // shared step unit, fed by the top dividend bit each cycle
  wrd_step #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_step (
    .rem     (rem),
    .bit_in  (num[OPERAND_BITS-1]),
    .divisor (div),
    .rem_next(rem_next),
    .quo_bit (quo_bit)
  );

  assign in.ready = (state == ST_IDLE);
  assign out_free = ~out_valid | out.ready;
  assign load_out = (state == ST_DRAIN) && out_free;

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register: load a finished word, clear once taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in.valid) begin
            div <= divisor_trim;
            cnt <= CNT_W'(OPERAND_BITS - 1);
            if (divisor_trim == '0) begin
              // zero divisor: quotient 0, remainder is the dividend
              num   <= '0;
              rem   <= dividend_trim;
              dz    <= 1'b1;
              state <= ST_DRAIN;
            end else begin
              num   <= dividend_trim;
              rem   <= '0;
              dz    <= 1'b0;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          // quotient bits shift in behind the consumed dividend bits
          num <= {num[OPERAND_BITS-2:0], quo_bit};
          rem <= rem_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            out_quo   <= MAX_BITS'(num);
            out_rem   <= MAX_BITS'(rem);
            out_dz    <= dz;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result words
  assign out.valid          = out_valid;
  assign out.quotient_lo    = out_quo[WORD_BITS-1:0];
  assign out.quotient_mid   = out_quo[2*WORD_BITS-1:WORD_BITS];
  assign out.quotient_hi    = out_quo[3*WORD_BITS-1:2*WORD_BITS];
  assign out.remainder_lo   = out_rem[WORD_BITS-1:0];
  assign out.remainder_mid  = out_rem[2*WORD_BITS-1:WORD_BITS];
  assign out.remainder_hi   = out_rem[3*WORD_BITS-1:2*WORD_BITS];
  assign out.divide_by_zero = out_dz;

endmodule

>>> rtl/core/wrd_step.sv
// wrd_step: one restoring division step, shift in a dividend bit and trial subtract
// depends on wrd_pkg for the default width; purely combinational
module wrd_step
  import wrd_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = DEFAULT_OPERAND_BITS
) (
  input  logic [OPERAND_BITS-1:0] rem,
  input  logic                    bit_in,
  input  logic [OPERAND_BITS-1:0] divisor,
  output logic [OPERAND_BITS-1:0] rem_next,
  output logic                    quo_bit
);

  logic [OPERAND_BITS:0]   shifted;
  logic [OPERAND_BITS+1:0] diff;

  // partial remainder with the next dividend bit, one bit wider to keep the carry
  assign shifted = {rem, bit_in};

  // trial subtract; the top bit is the borrow
  assign diff = {1'b0, shifted} - {2'b00, divisor};

  // no borrow means the divisor fits: keep the difference
  assign quo_bit  = ~diff[OPERAND_BITS+1];
  assign rem_next = quo_bit ? diff[OPERAND_BITS-1:0] : shifted[OPERAND_BITS-1:0];

endmodule
